// ===== rtl/core/ecd_pkg.sv =====
package ecd_pkg;

    // Field widths of the input and result beats.
    localparam int EPOCH_W  = 32;
    localparam int YEAR_W   = 12;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;

    // Internal widths: whole days since the epoch fit in 16 bits (at most 49710),
    // and a partial remainder stays below the largest divisor.
    localparam int DAYS_W  = 16;
    localparam int REM_W   = 17;
    localparam int SPAN_W  = 9;
    localparam int STEP_W  = 4;

    // Divisors of the time-of-day split.
    localparam logic [REM_W-1:0] SECS_PER_DAY  = REM_W'(86400);
    localparam logic [REM_W-1:0] SECS_PER_HOUR = REM_W'(3600);
    localparam logic [REM_W-1:0] SECS_PER_MIN  = REM_W'(60);

    // Reciprocals for the divisions. Seconds are first shifted right by 7, so
    // the day count is the 25-bit quotient by 675. Each reciprocal is rounded
    // up and is exact over the whole range of its dividend.
    localparam int DAY_PRE_SHIFT   = 7;
    localparam int DAY_X_W         = EPOCH_W - DAY_PRE_SHIFT;
    localparam int DAY_RECIP_W     = 26;
    localparam int DAY_PROD_W      = DAY_X_W + DAY_RECIP_W;
    localparam int DAY_RECIP_SHIFT = 35;
    localparam logic [DAY_RECIP_W-1:0] DAY_RECIP = DAY_RECIP_W'(50903317);

    localparam int HOUR_RECIP_W     = 18;
    localparam int HOUR_PROD_W      = REM_W + HOUR_RECIP_W;
    localparam int HOUR_RECIP_SHIFT = 29;
    localparam logic [HOUR_RECIP_W-1:0] HOUR_RECIP = HOUR_RECIP_W'(149131);

    localparam int MIN_RECIP_W     = 13;
    localparam int MIN_PROD_W      = REM_W + MIN_RECIP_W;
    localparam int MIN_RECIP_SHIFT = 18;
    localparam logic [MIN_RECIP_W-1:0] MIN_RECIP = MIN_RECIP_W'(4370);

    // Calendar constants.
    localparam logic [YEAR_W-1:0]  EPOCH_YEAR       = YEAR_W'(1970);
    localparam logic [YEAR_W-1:0]  NON_LEAP_CENTURY = YEAR_W'(2100);
    localparam logic [SPAN_W-1:0]  LEAP_YEAR_DAYS   = SPAN_W'(366);
    localparam logic [SPAN_W-1:0]  COMMON_YEAR_DAYS = SPAN_W'(365);
    localparam logic [DAY_W-1:0]   FEB_LEAP_DAYS    = DAY_W'(29);
    localparam logic [DAY_W-1:0]   LONG_MONTH_DAYS  = DAY_W'(31);
    localparam logic [MONTH_W-1:0] MONTH_JAN        = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] MONTH_FEB        = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] MONTH_DEC        = MONTH_W'(12);

    localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // Datapath operations selected by the control word.
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_DAY_QUO,
        OP_DAY_REM,
        OP_HOUR_QUO,
        OP_HOUR_REM,
        OP_MIN_QUO,
        OP_MIN_REM,
        OP_YEAR_STEP,
        OP_MONTH_STEP,
        OP_EMIT
    } op_t;

    // Sequencing of the step counter.
    typedef enum logic [2:0] {
        COND_NEXT,
        COND_GOTO,
        COND_LOOP,
        COND_WAIT_IN,
        COND_WAIT_OUT
    } cond_t;

    typedef struct packed {
        op_t               op;
        cond_t             cond;
        logic [STEP_W-1:0] target;
    } uword_t;

    // Sequencer to datapath.
    typedef struct packed {
        op_t      op;
        logic     fire;
    } ctrl_t;

    // Datapath to sequencer.
    typedef struct packed {
        logic more;
        logic out_busy;
    } stat_t;

    // Leap rule over the years that a 32-bit epoch reaches (1970 to 2106):
    // every fourth year, except the one non-leap century year in that span.
    // The year 2000 is divisible by 400 and stays a leap year.
    function automatic logic is_leap(input logic [YEAR_W-1:0] year);
        return (year[1:0] == 2'b00) && (year != NON_LEAP_CENTURY);
    endfunction

    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                    input logic leap);
        logic [MONTH_W-1:0] idx;
        idx = month - MONTH_JAN;
        if ((month == MONTH_FEB) && leap) begin
            return FEB_LEAP_DAYS;
        end
        if (!(month inside {[MONTH_JAN:MONTH_DEC]})) begin
            return LONG_MONTH_DAYS;
        end
        return MONTH_LEN[idx];
    endfunction

endpackage

// ===== rtl/core/epoch_to_calendar_date_unit.sv =====
// Conversion steps: a load step takes the input beat, six multiply steps split the seconds,
// then the walk advances one year per cycle and then one month per cycle.
// Input is ready again in the cycle after emit, so the next item can start while the
// result beat waits; the emit step waits while the previous beat is not yet taken.
// Reset (aresetn low, synchronous) idles the step counter and drops m_valid.
module epoch_to_calendar_date_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [ecd_pkg::EPOCH_W-1:0]  s_epoch_seconds,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [ecd_pkg::YEAR_W-1:0]   m_cal_year,
    output logic [ecd_pkg::MONTH_W-1:0]  m_cal_month,
    output logic [ecd_pkg::DAY_W-1:0]    m_cal_day,
    output logic [ecd_pkg::HOUR_W-1:0]   m_cal_hour,
    output logic [ecd_pkg::MINUTE_W-1:0] m_cal_minute,
    output logic [ecd_pkg::SECOND_W-1:0] m_cal_second
);
    import ecd_pkg::*;

    ctrl_t ctrl;
    stat_t stat;

    // Program sequencer with the control store.
    ecd_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    // Time-of-day split, calendar walk and result register.
    ecd_datapath u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .ctrl            (ctrl),
        .stat            (stat),
        .s_epoch_seconds (s_epoch_seconds),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_cal_year      (m_cal_year),
        .m_cal_month     (m_cal_month),
        .m_cal_day       (m_cal_day),
        .m_cal_hour      (m_cal_hour),
        .m_cal_minute    (m_cal_minute),
        .m_cal_second    (m_cal_second)
    );

endmodule

// ===== rtl/core/ecd_ucode_rom.sv =====
module ecd_ucode_rom (
    input  logic [ecd_pkg::STEP_W-1:0] addr,
    output ecd_pkg::uword_t            uword
);
    import ecd_pkg::*;

    // Conversion program. Loop steps repeat on themselves while the datapath
    // reports more work; wait steps hold until their handshake side is free.
    always_comb begin
        case (addr)
            4'd0:    uword = '{OP_LOAD,       COND_WAIT_IN,  4'd1};
            4'd1:    uword = '{OP_DAY_QUO,    COND_NEXT,     4'd0};
            4'd2:    uword = '{OP_DAY_REM,    COND_NEXT,     4'd0};
            4'd3:    uword = '{OP_HOUR_QUO,   COND_NEXT,     4'd0};
            4'd4:    uword = '{OP_HOUR_REM,   COND_NEXT,     4'd0};
            4'd5:    uword = '{OP_MIN_QUO,    COND_NEXT,     4'd0};
            4'd6:    uword = '{OP_MIN_REM,    COND_NEXT,     4'd0};
            4'd7:    uword = '{OP_YEAR_STEP,  COND_LOOP,     4'd7};
            4'd8:    uword = '{OP_MONTH_STEP, COND_LOOP,     4'd8};
            4'd9:    uword = '{OP_EMIT,       COND_WAIT_OUT, 4'd0};
            default: uword = '{OP_NOP,        COND_GOTO,     4'd0};
        endcase
    end

endmodule

// ===== rtl/core/ecd_sequencer.sv =====
module ecd_sequencer (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  ecd_pkg::stat_t stat,
    output ecd_pkg::ctrl_t ctrl
);
    import ecd_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    uword_t            uword;

    ecd_ucode_rom u_rom (
        .addr  (step_reg),
        .uword (uword)
    );

    // The first step is the only one that takes an input beat.
    assign s_ready = (step_reg == '0);

    // Step counter update and operation enable.
    always_comb begin
        ctrl.op      = uword.op;
        ctrl.fire    = 1'b1;
        step_next    = step_reg + STEP_W'(1);
        case (uword.cond)
            COND_NEXT: begin
                step_next = step_reg + STEP_W'(1);
            end
            COND_GOTO: begin
                step_next = uword.target;
            end
            COND_LOOP: begin
                if (stat.more) begin
                    step_next = uword.target;
                end
            end
            COND_WAIT_IN: begin
                ctrl.fire = s_valid;
                step_next = s_valid ? uword.target : step_reg;
            end
            COND_WAIT_OUT: begin
                ctrl.fire = !stat.out_busy;
                step_next = stat.out_busy ? step_reg : uword.target;
            end
            default: begin
                step_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

// ===== rtl/core/ecd_datapath.sv =====
module ecd_datapath (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  ecd_pkg::ctrl_t               ctrl,
    output ecd_pkg::stat_t               stat,
    input  logic [ecd_pkg::EPOCH_W-1:0]  s_epoch_seconds,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [ecd_pkg::YEAR_W-1:0]   m_cal_year,
    output logic [ecd_pkg::MONTH_W-1:0]  m_cal_month,
    output logic [ecd_pkg::DAY_W-1:0]    m_cal_day,
    output logic [ecd_pkg::HOUR_W-1:0]   m_cal_hour,
    output logic [ecd_pkg::MINUTE_W-1:0] m_cal_minute,
    output logic [ecd_pkg::SECOND_W-1:0] m_cal_second
);
    import ecd_pkg::*;

    // Working registers.
    logic [EPOCH_W-1:0]  epoch_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [DAYS_W-1:0]   days_reg;
    logic [YEAR_W-1:0]   year_reg;
    logic [MONTH_W-1:0]  month_reg;
    logic [HOUR_W-1:0]   hour_reg;
    logic [MINUTE_W-1:0] minute_reg;
    logic [SECOND_W-1:0] second_reg;

    // Result registers, kept apart so the next item can start while a beat waits.
    logic                m_valid_reg;
    logic [YEAR_W-1:0]   out_year_reg;
    logic [MONTH_W-1:0]  out_month_reg;
    logic [DAY_W-1:0]    out_day_reg;
    logic [HOUR_W-1:0]   out_hour_reg;
    logic [MINUTE_W-1:0] out_minute_reg;
    logic [SECOND_W-1:0] out_second_reg;

    logic [DAY_PROD_W-1:0]  day_prod;
    logic [EPOCH_W-1:0]     day_base;
    logic [EPOCH_W-1:0]     day_diff;
    logic [HOUR_PROD_W-1:0] hour_prod;
    logic [REM_W-1:0]       hour_diff;
    logic [MIN_PROD_W-1:0]  min_prod;
    logic [REM_W-1:0]       sec_diff;
    logic                   leap;
    logic [SPAN_W-1:0]      year_span;
    logic [DAY_W-1:0]       month_span;
    logic                   year_more;
    logic                   month_more;

    // Time-of-day split: each quotient comes from a reciprocal multiply, and
    // the remainder is taken back out on the following step.
    always_comb begin
        day_prod  = DAY_PROD_W'(epoch_reg[EPOCH_W-1:DAY_PRE_SHIFT]) * DAY_PROD_W'(DAY_RECIP);
        day_base  = EPOCH_W'(days_reg) * EPOCH_W'(SECS_PER_DAY);
        day_diff  = epoch_reg - day_base;
        hour_prod = HOUR_PROD_W'(rem_reg) * HOUR_PROD_W'(HOUR_RECIP);
        hour_diff = rem_reg - REM_W'(hour_reg) * SECS_PER_HOUR;
        min_prod  = MIN_PROD_W'(rem_reg) * MIN_PROD_W'(MIN_RECIP);
        sec_diff  = rem_reg - REM_W'(minute_reg) * SECS_PER_MIN;
    end

    // Year and month spans for the current position in the calendar walk.
    always_comb begin
        leap       = is_leap(year_reg);
        year_span  = leap ? LEAP_YEAR_DAYS : COMMON_YEAR_DAYS;
        month_span = month_days(month_reg, leap);
        year_more  = (days_reg >= DAYS_W'(year_span));
        month_more = (month_reg != MONTH_DEC) && (days_reg >= DAYS_W'(month_span));
    end

    // Loop status for the sequencer.
    always_comb begin
        case (ctrl.op)
            OP_YEAR_STEP:  stat.more = year_more;
            OP_MONTH_STEP: stat.more = month_more;
            default:       stat.more = 1'b0;
        endcase
        stat.out_busy = m_valid_reg && !m_ready;
    end

    // Datapath operations.
    always_ff @(posedge aclk) begin
        if (ctrl.fire) begin
            case (ctrl.op)
                OP_LOAD: begin
                    epoch_reg <= s_epoch_seconds;
                end
                OP_DAY_QUO: begin
                    days_reg <= day_prod[DAY_RECIP_SHIFT +: DAYS_W];
                end
                OP_DAY_REM: begin
                    rem_reg <= day_diff[REM_W-1:0];
                end
                OP_HOUR_QUO: begin
                    hour_reg <= hour_prod[HOUR_RECIP_SHIFT +: HOUR_W];
                end
                OP_HOUR_REM: begin
                    rem_reg <= hour_diff;
                end
                OP_MIN_QUO: begin
                    minute_reg <= min_prod[MIN_RECIP_SHIFT +: MINUTE_W];
                end
                OP_MIN_REM: begin
                    second_reg <= sec_diff[SECOND_W-1:0];
                    year_reg   <= EPOCH_YEAR;
                    month_reg  <= MONTH_JAN;
                end
                OP_YEAR_STEP: begin
                    if (year_more) begin
                        days_reg <= days_reg - DAYS_W'(year_span);
                        year_reg <= year_reg + YEAR_W'(1);
                    end
                end
                OP_MONTH_STEP: begin
                    if (month_more) begin
                        days_reg  <= days_reg - DAYS_W'(month_span);
                        month_reg <= month_reg + MONTH_W'(1);
                    end
                end
                OP_EMIT: begin
                    out_year_reg   <= year_reg;
                    out_month_reg  <= month_reg;
                    out_day_reg    <= days_reg[DAY_W-1:0] + DAY_W'(1);
                    out_hour_reg   <= hour_reg;
                    out_minute_reg <= minute_reg;
                    out_second_reg <= second_reg;
                end
                default: begin
                end
            endcase
        end
    end

    // Result beat valid: set by the emit step, cleared when the beat is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl.fire && (ctrl.op == OP_EMIT)) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_cal_year   = out_year_reg;
    assign m_cal_month  = out_month_reg;
    assign m_cal_day    = out_day_reg;
    assign m_cal_hour   = out_hour_reg;
    assign m_cal_minute = out_minute_reg;
    assign m_cal_second = out_second_reg;

endmodule
